FILE: hw/rtl/msort_pkg.sv
`default_nettype none

package msort_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_CHK,
        ST_RUN_CHK,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_OUT_RD,
        ST_OUT_SHOW
    } msort_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // store input value, or flag overflow when full
        logic sort_init;  // run width 1, source bank 0
        logic pass_init;  // first run of a pass
        logic run_init;   // set up pointers for the run at lo
        logic run_next;   // step lo to the next run pair
        logic pass_next;  // double run width, swap banks
        logic rd_issue;   // read heads of both runs
        logic mrg_wr;     // write smaller head to destination bank
        logic out_init;   // output index to zero
        logic out_rd;     // read sorted element at output index
        logic out_next;   // advance output index
        logic clear;      // batch done, drop count and overflow flag
    } msort_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic width_ge_n; // all passes done
        logic lo_ge_n;    // all runs of this pass done
        logic k_eq_hi;    // current merge finished
        logic k_last;     // output index on final element
    } msort_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/merge_sort.sv
// merge_sort: batch sorter for signed 32-bit integers
// input stream (s_*): one element per request in s_tdata, s_tlast marks the
//   final element of a batch; requests are taken only while the block loads
// output stream (m_*): the batch in ascending order, m_tlast on the final
//   element, m_tuser set on every element of a batch that overflowed
// a batch longer than MAX_ELEMENTS keeps its first MAX_ELEMENTS elements
// loading accepts an element whenever s_tvalid is high
// sorting is a bottom-up merge between two memory banks, ceil(log2 n) passes;
//   each merged element takes a registered read of both run heads, then
//   compare and write; each run pair and each pass add their check states
// output reads each element from memory, then holds it for the request
// equal values leave in arrival order
// reset returns to loading with an empty batch; no memory clearing is needed
// a stalled receiver holds the current result in place, nothing is lost;
//   no new input is taken until the whole batch has been delivered
`default_nettype none

module merge_sort
    import msort_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // sorted_value
    output logic             m_tlast,
    output logic             m_tuser    // overflow
);

    msort_cmd_t  cmd;
    msort_sts_t  sts;
    logic [DATA_W-1:0] rd_value;
    logic        ovf;

    msort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    msort_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_value (s_tdata),
        .sts      (sts),
        .rd_value (rd_value),
        .ovf      (ovf)
    );

    // output fields come from the held read register and flags
    assign m_tdata = rd_value;
    assign m_tlast = sts.k_last;
    assign m_tuser = ovf;

endmodule

`default_nettype wire

FILE: hw/rtl/msort_dp.sv
`default_nettype none

module msort_dp
    import msort_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire msort_cmd_t        cmd,
    input  wire logic [DATA_W-1:0] in_value,
    output msort_sts_t             sts,
    output logic [DATA_W-1:0]      rd_value,
    output logic                   ovf
);

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned WW = CW + 2;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);

    // two banks, merge passes ping-pong between them
    logic [DATA_W-1:0] mem0 [MAX_ELEMENTS];
    logic [DATA_W-1:0] mem1 [MAX_ELEMENTS];

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [WW-1:0] width_reg, width_next;
    logic [WW-1:0] lo_reg, lo_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic          bank_reg, bank_next;

    logic [DATA_W-1:0] rd0_i_reg, rd0_j_reg, rd1_i_reg, rd1_j_reg;
    logic [DATA_W-1:0] head_i, head_j, wr_data;
    logic [AW-1:0]     rd_addr_i, rd_addr_j, wr_addr;
    logic              take_i;
    logic              wr0_en, wr1_en;
    logic [WW-1:0]     n_w, mid_c, hi_c;

    assign n_w   = WW'(count_reg);
    assign mid_c = lo_reg + width_reg;
    assign hi_c  = lo_reg + (width_reg << 1);

    assign head_i = bank_reg ? rd1_i_reg : rd0_i_reg;
    assign head_j = bank_reg ? rd1_j_reg : rd0_j_reg;

    // stable: left run wins ties
    assign take_i = (i_reg < mid_reg) &&
                    ((j_reg >= hi_reg) || ($signed(head_i) <= $signed(head_j)));
    assign wr_data = cmd.load ? in_value : (take_i ? head_i : head_j);

    assign rd_addr_i = cmd.out_rd ? k_reg[AW-1:0] : i_reg[AW-1:0];
    assign rd_addr_j = j_reg[AW-1:0];
    assign wr_addr   = cmd.load ? count_reg[AW-1:0] : k_reg[AW-1:0];

    assign wr0_en = (cmd.load && (count_reg != CNT_MAX)) || (cmd.mrg_wr && bank_reg);
    assign wr1_en = cmd.mrg_wr && !bank_reg;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        bank_next  = bank_reg;
        if (cmd.load) begin
            if (count_reg != CNT_MAX) begin
                count_next = count_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.sort_init) begin
            width_next = WW'(1);
            bank_next  = 1'b0;
        end
        if (cmd.pass_init) begin
            lo_next = '0;
        end
        if (cmd.run_init) begin
            mid_next = (mid_c > n_w) ? count_reg : mid_c[CW-1:0];
            hi_next  = (hi_c > n_w) ? count_reg : hi_c[CW-1:0];
            i_next   = lo_reg[CW-1:0];
            k_next   = lo_reg[CW-1:0];
            j_next   = (mid_c > n_w) ? count_reg : mid_c[CW-1:0];
        end
        if (cmd.run_next) begin
            lo_next = hi_c;
        end
        if (cmd.pass_next) begin
            width_next = width_reg << 1;
            bank_next  = !bank_reg;
        end
        if (cmd.mrg_wr) begin
            k_next = k_reg + 1'b1;
            if (take_i) begin
                i_next = i_reg + 1'b1;
            end else begin
                j_next = j_reg + 1'b1;
            end
        end
        if (cmd.out_init) begin
            k_next = '0;
        end
        if (cmd.out_next) begin
            k_next = k_reg + 1'b1;
        end
        if (cmd.clear) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            width_reg <= '0;
            lo_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            bank_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr0_en) begin
            mem0[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue || cmd.out_rd) begin
            rd0_i_reg <= mem0[rd_addr_i];
            rd0_j_reg <= mem0[rd_addr_j];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr1_en) begin
            mem1[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue || cmd.out_rd) begin
            rd1_i_reg <= mem1[rd_addr_i];
            rd1_j_reg <= mem1[rd_addr_j];
        end
    end

    always_comb begin
        sts.width_ge_n = (width_reg >= n_w);
        sts.lo_ge_n    = (lo_reg >= n_w);
        sts.k_eq_hi    = (k_reg == hi_reg);
        sts.k_last     = ((k_reg + 1'b1) == count_reg);
    end

    assign rd_value = head_i;
    assign ovf      = ovf_reg;

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        i_reg <= mid_reg)
        else $error("left run pointer passed its end");

    a_right_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mrg_wr |-> (j_reg <= hi_reg) && (k_reg < hi_reg))
        else $error("merge write outside its run");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("element count above capacity");

endmodule

`default_nettype wire

FILE: hw/rtl/msort_ctrl.sv
`default_nettype none

module msort_ctrl
    import msort_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tlast,
    input  wire logic       m_tready,
    input  wire msort_sts_t sts,
    output logic            s_tready,
    output logic            m_tvalid,
    output msort_cmd_t      cmd
);

    msort_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_PASS_CHK;
                    end
                end
            end
            ST_PASS_CHK: begin
                if (sts.width_ge_n) begin
                    cmd.out_init = 1'b1;
                    state_next   = ST_OUT_RD;
                end else begin
                    cmd.pass_init = 1'b1;
                    state_next    = ST_RUN_CHK;
                end
            end
            ST_RUN_CHK: begin
                if (sts.lo_ge_n) begin
                    cmd.pass_next = 1'b1;
                    state_next    = ST_PASS_CHK;
                end else begin
                    cmd.run_init = 1'b1;
                    state_next   = ST_MRG_RD;
                end
            end
            ST_MRG_RD: begin
                if (sts.k_eq_hi) begin
                    cmd.run_next = 1'b1;
                    state_next   = ST_RUN_CHK;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_MRG_WR;
                end
            end
            ST_MRG_WR: begin
                cmd.mrg_wr = 1'b1;
                state_next = ST_MRG_RD;
            end
            ST_OUT_RD: begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (sts.k_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

endmodule

`default_nettype wire
